/* design/two_region_unit_map_allocator_defines.svh */
// Assertion helpers used by the allocator module.
`ifndef TWO_REGION_UNIT_MAP_ALLOCATOR_DEFINES_SVH
`define TWO_REGION_UNIT_MAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define TRUMA_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define TRUMA_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/truma_pkg.sv */
package truma_pkg;

    localparam int WORD_W    = 32;
    localparam int BIT_IDX_W = 5;
    localparam int POP_W     = 6;
    localparam int CNT_W     = 12;
    localparam int COUNT_W   = 11;
    localparam int START_W   = 10;
    localparam int PRIO_W    = 2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [PRIO_W-1:0] PRIO_REALTIME = 2'd0;

    // Summary of the free, in-range units of one map word.
    typedef struct packed {
        logic [WORD_W-1:0]    free_bits;
        logic [POP_W-1:0]     free_cnt;
        logic [BIT_IDX_W-1:0] low_idx;
    } t_word_info;

endpackage

/* design/two_region_unit_map_allocator.sv */
// Flow: a beat with an empty range goes straight to DONE; otherwise the scan walks the
//   32-unit map words of its range, and an allocation that ends inside a word then places
//   its units in that word one by one (up to 32).
// Throughput: one item at a time, next beat taken the cycle after the result loads; the map
//   RAM read-modify-write of one word per cycle sets the pace (30 words for a normal scan).
// Reset: synchronous, active low; counters return to region sizes, per-word valid bits clear so the map reads as free.
`include "two_region_unit_map_allocator_defines.svh"

module two_region_unit_map_allocator #(
    parameter int MAP_UNITS     = 1024,
    parameter int REALTIME_BASE = 960
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_kind,
    input  logic [truma_pkg::PRIO_W-1:0]         i_priority_level,
    input  logic [truma_pkg::COUNT_W-1:0]        i_unit_count,
    input  logic [truma_pkg::START_W-1:0]        i_start_unit,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [truma_pkg::CNT_W-1:0]   o_start_position,
    output logic signed [truma_pkg::CNT_W-1:0]   o_normal_units_left,
    output logic signed [truma_pkg::CNT_W-1:0]   o_realtime_units_left
);

    // The whole map reads as free right after reset, so no clearing pass is needed.

    localparam int WORD_W   = truma_pkg::WORD_W;
    localparam int CNT_W    = truma_pkg::CNT_W;
    localparam int COUNT_W  = truma_pkg::COUNT_W;
    localparam int BI_W     = truma_pkg::BIT_IDX_W;
    localparam int WORDS    = (MAP_UNITS + WORD_W - 1) / WORD_W;
    localparam int AW       = $clog2(WORDS);
    localparam int POS_W    = $clog2(MAP_UNITS + 1);
    localparam int SW       = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int NORM_END = (REALTIME_BASE < MAP_UNITS) ? REALTIME_BASE : MAP_UNITS;

    localparam logic [SW-1:0]    MAP_END      = SW'(MAP_UNITS);
    localparam logic [SW-1:0]    NORM_END_P   = SW'(NORM_END);
    localparam logic [SW-1:0]    RT_BASE_P    = SW'(REALTIME_BASE);
    localparam logic [CNT_W-1:0] NORMAL_RESET = CNT_W'(REALTIME_BASE);
    localparam logic [CNT_W-1:0] RT_RESET     = CNT_W'(MAP_UNITS - NORM_END);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_BIT  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Control state
    t_state              r_state, n_state;
    logic                r_rd_more, n_rd_more;
    logic                r_pv;
    logic                r_out_valid, n_out_valid;
    logic [CNT_W-1:0]    r_nm, n_nm;
    logic [CNT_W-1:0]    r_rt, n_rt;
    logic [WORDS-1:0]    r_row_valid;

    // Item payload and scan position
    logic                r_kind, n_kind;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [COUNT_W-1:0]  r_left, n_left;
    logic [SW-1:0]       r_lo, n_lo;
    logic [SW-1:0]       r_hi, n_hi;
    logic [SW-1:0]       r_stop, n_stop;
    logic [AW-1:0]       r_rd_word, n_rd_word;
    logic [AW-1:0]       r_last_word, n_last_word;
    logic [AW-1:0]       r_pw;
    logic [AW-1:0]       r_bw, n_bw;
    logic [WORD_W-1:0]   r_word, n_word;
    logic                r_rd_row_ok;
    logic [CNT_W-1:0]    r_out_pos;
    logic [CNT_W-1:0]    r_out_nm;
    logic [CNT_W-1:0]    r_out_rt;

    // Accept-time decode
    logic                in_acc;
    logic [SW-1:0]       acc_sum;
    logic [SW-1:0]       acc_lo;
    logic [SW-1:0]       acc_hi;
    logic [SW-1:0]       acc_hi_m1;
    logic                acc_empty;

    // Map RAM and word evaluation
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic [AW-1:0]       ev_idx;
    logic [WORD_W-1:0]   ev_data;
    logic [WORD_W-1:0]   ev_mask;
    truma_pkg::t_word_info ev_info;
    logic                out_load;

    // Take a new beat only between items; a held result does not block acceptance.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Region bounds of the incoming beat. Allocate walks a whole region, free walks its range
    // clipped at the map end.
    always_comb begin
        acc_sum = SW'(i_start_unit) + SW'(i_unit_count);
        if (i_kind == truma_pkg::KIND_ALLOC) begin
            if (i_priority_level == truma_pkg::PRIO_REALTIME) begin
                acc_lo = NORM_END_P;
                acc_hi = MAP_END;
            end else begin
                acc_lo = '0;
                acc_hi = NORM_END_P;
            end
            acc_empty = (i_unit_count == '0) || (acc_lo >= acc_hi);
        end else begin
            acc_lo    = SW'(i_start_unit);
            acc_hi    = (acc_sum > MAP_END) ? MAP_END : acc_sum;
            acc_empty = (acc_hi <= acc_lo);
        end
        acc_hi_m1 = acc_hi - SW'(1);
    end

    // Stream reads one word ahead of the write-back while scanning.
    assign ram_rd_en   = (r_state == S_RUN) && r_rd_more;
    assign ram_rd_addr = r_rd_word;

    // Evaluate either the word just read or the word held for unit-by-unit placement.
    // Rows never written since reset read as all free.
    assign ev_idx  = (r_state == S_BIT) ? r_bw : r_pw;
    assign ev_data = (r_state == S_BIT) ? r_word : (r_rd_row_ok ? ram_rd_data : '0);

    always_comb begin
        logic [SW-1:0] pos;
        for (int b = 0; b < WORD_W; b++) begin
            pos        = SW'({ev_idx, BI_W'(b)});
            ev_mask[b] = (pos >= r_lo) && (pos < r_hi);
        end
    end

    truma_word_eval u_eval (
        .i_data (ev_data),
        .i_mask (ev_mask),
        .o_info (ev_info)
    );

    truma_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_rd_more   = r_rd_more;
        n_nm        = r_nm;
        n_rt        = r_rt;
        n_kind      = r_kind;
        n_count     = r_count;
        n_left      = r_left;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_stop      = r_stop;
        n_rd_word   = r_rd_word;
        n_last_word = r_last_word;
        n_bw        = r_bw;
        n_word      = r_word;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_pw;
        ram_wr_data = ev_data | ev_info.free_bits;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind      = i_kind;
                    n_count     = i_unit_count;
                    n_left      = i_unit_count;
                    n_lo        = acc_lo;
                    n_hi        = acc_hi;
                    n_rd_more   = 1'b1;
                    n_rd_word   = acc_lo[AW+BI_W-1:BI_W];
                    n_last_word = acc_hi_m1[AW+BI_W-1:BI_W];
                    if (i_kind == truma_pkg::KIND_ALLOC) begin
                        // Charge the region up front; availability is not checked.
                        if (i_priority_level == truma_pkg::PRIO_REALTIME) begin
                            n_rt = r_rt - CNT_W'(i_unit_count);
                        end else begin
                            n_nm = r_nm - CNT_W'(i_unit_count);
                        end
                        n_stop = acc_lo;
                    end else begin
                        // Credit goes by the region of the first unit, full count.
                        if (SW'(i_start_unit) >= RT_BASE_P) begin
                            n_rt = r_rt + CNT_W'(i_unit_count);
                        end else begin
                            n_nm = r_nm + CNT_W'(i_unit_count);
                        end
                        n_stop = '0;
                    end
                    n_state = acc_empty ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (r_rd_more) begin
                    n_rd_word = r_rd_word + AW'(1);
                    if (r_rd_word == r_last_word) begin
                        n_rd_more = 1'b0;
                    end
                end
                if (r_pv) begin
                    if (r_kind == truma_pkg::KIND_FREE) begin
                        // Clear the in-range units of this word.
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ev_data & ~ev_mask;
                        if (r_pw == r_last_word) begin
                            n_state = S_DONE;
                        end
                    end else if (r_left > COUNT_W'(ev_info.free_cnt)) begin
                        // Whole word taken: mark every free unit and move on.
                        ram_wr_en = 1'b1;
                        n_left    = r_left - COUNT_W'(ev_info.free_cnt);
                        if (r_pw == r_last_word) begin
                            n_stop  = r_hi;
                            n_state = S_DONE;
                        end
                    end else begin
                        // The request ends inside this word: hold it and place unit by unit.
                        n_word  = ev_data;
                        n_bw    = r_pw;
                        n_state = S_BIT;
                    end
                end
            end
            S_BIT: begin
                n_word[ev_info.low_idx] = 1'b1;
                n_left                  = r_left - COUNT_W'(1);
                if (r_left == COUNT_W'(1)) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_bw;
                    ram_wr_data = n_word;
                    n_stop      = SW'({r_bw, ev_info.low_idx}) + SW'(1);
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load from DONE, drop once the beat is taken.
    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_more   <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_nm        <= NORMAL_RESET;
            r_rt        <= RT_RESET;
            r_row_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_rd_more   <= n_rd_more;
            r_pv        <= ram_rd_en;
            r_out_valid <= n_out_valid;
            r_nm        <= n_nm;
            r_rt        <= n_rt;
            if (ram_wr_en) begin
                r_row_valid[ram_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_count     <= n_count;
        r_left      <= n_left;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_stop      <= n_stop;
        r_rd_word   <= n_rd_word;
        r_last_word <= n_last_word;
        r_bw        <= n_bw;
        r_word      <= n_word;
        if (ram_rd_en) begin
            r_pw        <= r_rd_word;
            r_rd_row_ok <= r_row_valid[r_rd_word];
        end
        if (out_load) begin
            r_out_pos <= (r_kind == truma_pkg::KIND_ALLOC) ?
                         CNT_W'(r_stop - SW'(r_count)) : '0;
            r_out_nm  <= r_nm;
            r_out_rt  <= r_rt;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_start_position      = r_out_pos;
    assign o_normal_units_left   = r_out_nm;
    assign o_realtime_units_left = r_out_rt;

    `TRUMA_CHECK_NOW(a_rmw_no_overlap, ram_rd_en && ram_wr_en, ram_rd_addr != ram_wr_addr,
                     "map read and write hit the same word")
    `TRUMA_CHECK_NEXT(a_accept_blocks, in_acc, o_in_stall, "second beat entered during an item")
    `TRUMA_CHECK_NOW(a_bit_left, r_state == S_BIT, r_left != '0, "unit placement with nothing left")
    `TRUMA_CHECK_NEXT(a_done_loads, out_load, o_out_valid && (r_state == S_IDLE),
                      "result not loaded on finish")

endmodule

/* design/truma_ram.sv */
module truma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/truma_word_eval.sv */
module truma_word_eval (
    input  logic [truma_pkg::WORD_W-1:0] i_data,
    input  logic [truma_pkg::WORD_W-1:0] i_mask,
    output truma_pkg::t_word_info        o_info
);

    // Count and locate free units per byte, then merge the four bytes.
    always_comb begin
        logic [truma_pkg::WORD_W-1:0] free_bits;
        logic [3:0]                   byte_cnt [4];
        logic [2:0]                   byte_idx [4];
        logic [3:0]                   byte_has;
        free_bits = ~i_data & i_mask;
        for (int g = 0; g < 4; g++) begin
            byte_cnt[g] = '0;
            byte_idx[g] = '0;
            byte_has[g] = |free_bits[g*8 +: 8];
            for (int b = 7; b >= 0; b--) begin
                byte_cnt[g] = byte_cnt[g] + 4'(free_bits[g*8 + b]);
                if (free_bits[g*8 + b]) begin
                    byte_idx[g] = 3'(b);
                end
            end
        end
        o_info.free_bits = free_bits;
        o_info.free_cnt  = truma_pkg::POP_W'(byte_cnt[0]) + truma_pkg::POP_W'(byte_cnt[1])
                         + truma_pkg::POP_W'(byte_cnt[2]) + truma_pkg::POP_W'(byte_cnt[3]);
        o_info.low_idx   = '0;
        for (int g = 3; g >= 0; g--) begin
            if (byte_has[g]) begin
                o_info.low_idx = {2'(g), byte_idx[g]};
            end
        end
    end

endmodule

/* sim/tb_two_region_unit_map_allocator.sv */
`timescale 1ns / 100ps

module tb_two_region_unit_map_allocator;

    localparam int MAP_UNITS        = 1024;
    localparam int REALTIME_BASE    = 960;
    localparam int SETTLE_CYCLES    = 100;   // well past the longest scan plus placement
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_PER_PHASE = 600;
    localparam int PRIO_W           = truma_pkg::PRIO_W;
    localparam int COUNT_W          = truma_pkg::COUNT_W;
    localparam int START_W          = truma_pkg::START_W;
    localparam int CNT_W            = truma_pkg::CNT_W;

    // One request beat as seen on the input ports.
    typedef struct packed {
        logic               kind;
        logic [PRIO_W-1:0]  prio;
        logic [COUNT_W-1:0] count;
        logic [START_W-1:0] start;
    } t_unit_request;

    // One result beat as seen on the output ports.
    typedef struct packed {
        logic signed [CNT_W-1:0] position;
        logic signed [CNT_W-1:0] normal_left;
        logic signed [CNT_W-1:0] realtime_left;
    } t_unit_reply;

    logic                       i_clk            = 1'b0;
    logic                       i_rst_n          = 1'b0;
    logic                       i_in_valid       = 1'b0;
    logic                       i_kind           = truma_pkg::KIND_ALLOC;
    logic [PRIO_W-1:0]          i_priority_level = '0;
    logic [COUNT_W-1:0]         i_unit_count     = '0;
    logic [START_W-1:0]         i_start_unit     = '0;
    logic                       i_out_stall      = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [CNT_W-1:0]    o_start_position;
    logic signed [CNT_W-1:0]    o_normal_units_left;
    logic signed [CNT_W-1:0]    o_realtime_units_left;

    // Shadow copy of the allocator state, advanced at every accepted beat.
    bit   [MAP_UNITS-1:0]       unit_used;
    logic [CNT_W-1:0]           normal_free;
    logic [CNT_W-1:0]           realtime_free;

    t_unit_request              pending_requests[$];
    t_unit_reply                expected_replies[$];

    int                         tx_idle_pct;
    int                         rx_idle_pct;
    int                         fault_count = 0;

    always #10 i_clk = ~i_clk;

    two_region_unit_map_allocator #(
        .MAP_UNITS     (MAP_UNITS),
        .REALTIME_BASE (REALTIME_BASE)
    ) DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_kind                (i_kind),
        .i_priority_level      (i_priority_level),
        .i_unit_count          (i_unit_count),
        .i_start_unit          (i_start_unit),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_start_position      (o_start_position),
        .o_normal_units_left   (o_normal_units_left),
        .o_realtime_units_left (o_realtime_units_left)
    );

    // Apply one request to the shadow map and counters and return the result it must produce.
    // Allocate walks its region upward, marking free units until the count is met or the
    // region ends; the counter drops by the full count either way. Free clears its range up to
    // the map end and credits the region holding the start unit, already-free units included.
    function automatic t_unit_reply apply_request(t_unit_request req);
        t_unit_reply reply;
        int unsigned pos;
        int unsigned stop;
        int unsigned left;
        int unsigned last;
        reply.position = '0;
        if (req.kind == truma_pkg::KIND_ALLOC) begin
            left = req.count;
            if (req.prio == truma_pkg::PRIO_REALTIME) begin
                pos           = REALTIME_BASE;
                stop          = MAP_UNITS;
                realtime_free = realtime_free - CNT_W'(req.count);
            end else begin
                pos         = 0;
                stop        = REALTIME_BASE;
                normal_free = normal_free - CNT_W'(req.count);
            end
            while (pos < stop && left > 0) begin
                if (!unit_used[pos]) begin
                    unit_used[pos] = 1'b1;
                    left--;
                end
                pos++;
            end
            reply.position = CNT_W'(pos - req.count);
        end else begin
            last = req.start + req.count;
            if (last > MAP_UNITS)
                last = MAP_UNITS;
            for (int unsigned u = req.start; u < last; u++)
                unit_used[u] = 1'b0;
            if (req.start >= REALTIME_BASE)
                realtime_free = realtime_free + CNT_W'(req.count);
            else
                normal_free = normal_free + CNT_W'(req.count);
        end
        reply.normal_left   = normal_free;
        reply.realtime_left = realtime_free;
        return reply;
    endfunction

    function automatic void report_fault(string what, t_unit_reply want, t_unit_reply seen);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t %s: expected pos/normal/realtime %0d/%0d/%0d, got %0d/%0d/%0d",
                     $time, what, want.position, want.normal_left, want.realtime_left,
                     seen.position, seen.normal_left, seen.realtime_left);
    endfunction

    function automatic void queue_request(logic kind, logic [PRIO_W-1:0] prio,
                                          int unsigned count, int unsigned start);
        t_unit_request req;
        req.kind  = kind;
        req.prio  = prio;
        req.count = COUNT_W'(count);
        req.start = START_W'(start);
        pending_requests.push_back(req);
    endfunction

    // Random traffic: mostly small counts so the map fragments, a few large ones up to full-map size.
    // Free starts lean toward the low normal region, where allocations pile up, and the
    // realtime region. Unused fields of each kind still carry random values.
    function automatic void queue_random(int n);
        t_unit_request req;
        int unsigned   roll;
        for (int i = 0; i < n; i++) begin
            req.kind  = ($urandom_range(0, 1) == 0) ? truma_pkg::KIND_ALLOC : truma_pkg::KIND_FREE;
            req.prio  = PRIO_W'($urandom_range(0, 3));
            req.start = START_W'($urandom_range(0, MAP_UNITS - 1));
            roll = $urandom_range(0, 99);
            if (roll < 70)
                req.count = COUNT_W'($urandom_range(0, 24));
            else if (roll < 95)
                req.count = COUNT_W'($urandom_range(25, 256));
            else
                req.count = COUNT_W'($urandom_range(257, MAP_UNITS));
            if (req.kind == truma_pkg::KIND_FREE) begin
                roll = $urandom_range(0, 99);
                if (roll < 65)
                    req.start = START_W'($urandom_range(0, 511));
                else if (roll < 85)
                    req.start = START_W'($urandom_range(REALTIME_BASE, MAP_UNITS - 1));
            end
            pending_requests.push_back(req);
        end
    endfunction

    // Hold until every queued beat is accepted and every result is back.
    // Sample on the falling edge so the handshake state has settled.
    task automatic wait_for_quiet();
        while (pending_requests.size() != 0 || i_in_valid || expected_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // Request driver: predict on acceptance, hold a stalled beat, otherwise launch the
    // next pending request unless this cycle is picked as a sender idle.
    always @(posedge i_clk) begin : drive_requests
        t_unit_request taken;
        t_unit_request next_req;
        logic          launch;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                taken.kind  = i_kind;
                taken.prio  = i_priority_level;
                taken.count = i_unit_count;
                taken.start = i_start_unit;
                expected_replies.push_back(apply_request(taken));
            end
            // A stalled beat stays exactly as it is.
            if (!(i_in_valid && o_in_stall)) begin
                launch = pending_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct;
                if (launch) begin
                    next_req = pending_requests.pop_front();
                    i_kind           <= next_req.kind;
                    i_priority_level <= next_req.prio;
                    i_unit_count     <= next_req.count;
                    i_start_unit     <= next_req.start;
                end
                i_in_valid <= launch;
            end
        end
    end

    // Result monitor: compare every accepted result against the oldest prediction and
    // stall the output at the current receiver idle rate.
    always @(posedge i_clk) begin : check_replies
        t_unit_reply seen;
        t_unit_reply want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen.position      = o_start_position;
                seen.normal_left   = o_normal_units_left;
                seen.realtime_left = o_realtime_units_left;
                if (expected_replies.size() == 0) begin
                    report_fault("result with nothing outstanding", '0, seen);
                end else begin
                    want = expected_replies.pop_front();
                    if (seen.position !== want.position ||
                        seen.normal_left !== want.normal_left ||
                        seen.realtime_left !== want.realtime_left)
                        report_fault("result mismatch", want, seen);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    initial begin : run_stimulus
        unit_used     = '0;
        normal_free   = CNT_W'(REALTIME_BASE);
        realtime_free = CNT_W'(MAP_UNITS - REALTIME_BASE);
        tx_idle_pct   = 7;
        rx_idle_pct   = 63;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero counts: allocate returns the region start, nothing changes.
        queue_request(truma_pkg::KIND_ALLOC, truma_pkg::PRIO_REALTIME, 0, 1023);
        queue_request(truma_pkg::KIND_ALLOC, 2'd1, 0, 0);
        queue_request(truma_pkg::KIND_FREE,  2'd3, 0, 512);
        // Plain allocations from the bottom of the normal region on every non-realtime priority.
        queue_request(truma_pkg::KIND_ALLOC, 2'd1, 10, 0);
        queue_request(truma_pkg::KIND_ALLOC, 2'd2, 5, 1023);
        queue_request(truma_pkg::KIND_ALLOC, 2'd3, 1, 0);
        // Punch a hole and refill it; the scan must skip used units past the hole.
        queue_request(truma_pkg::KIND_FREE,  2'd0, 4, 3);
        queue_request(truma_pkg::KIND_ALLOC, 2'd1, 6, 0);
        // Free units that were never used: counter is still credited.
        queue_request(truma_pkg::KIND_FREE,  2'd2, 50, 100);
        // Fill the realtime region, then ask for more from an empty region.
        queue_request(truma_pkg::KIND_ALLOC, truma_pkg::PRIO_REALTIME, 64, 0);
        queue_request(truma_pkg::KIND_ALLOC, truma_pkg::PRIO_REALTIME, 1, 0);
        // Free running past the map end, credited in full to realtime.
        queue_request(truma_pkg::KIND_FREE,  2'd1, 1024, 1023);
        queue_request(truma_pkg::KIND_FREE,  2'd0, 64, 960);
        // Overallocate the normal region repeatedly until its counter wraps.
        queue_request(truma_pkg::KIND_ALLOC, 2'd3, 1024, 0);
        queue_request(truma_pkg::KIND_ALLOC, 2'd2, 1024, 682);
        queue_request(truma_pkg::KIND_ALLOC, 2'd1, 1024, 341);
        // Range straddling the region boundary credits the normal side.
        queue_request(truma_pkg::KIND_FREE,  2'd3, 2, 959);
        // Clear the whole map, then overallocate realtime hard.
        queue_request(truma_pkg::KIND_FREE,  2'd2, 1024, 0);
        queue_request(truma_pkg::KIND_ALLOC, truma_pkg::PRIO_REALTIME, 1024, 0);
        queue_request(truma_pkg::KIND_FREE,  2'd1, 1, 1023);
        // Fill all but one unit of the normal region, then stop at its end with one left over.
        queue_request(truma_pkg::KIND_ALLOC, 2'd2, 959, 0);
        queue_request(truma_pkg::KIND_ALLOC, 2'd1, 2, 0);
        wait_for_quiet();

        // Slow receiver, with a full drain in the middle.
        queue_random(RANDOM_PER_PHASE / 2);
        wait_for_quiet();
        queue_random(RANDOM_PER_PHASE / 2);
        wait_for_quiet();

        // Slow sender.
        tx_idle_pct = 63;
        rx_idle_pct = 7;
        queue_random(RANDOM_PER_PHASE);
        wait_for_quiet();

        // Back to back, no idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(RANDOM_PER_PHASE);
        wait_for_quiet();

        // Let any stray result show up before the verdict.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #20000000;
        $display("FAILURE");
        $finish;
    end

endmodule
